[design/maf_pkg.sv]
// Shared constants for the moving average filter.
package maf_pkg;

    localparam int MAX_WINDOW_DEF  = 256;
    localparam int SAMPLE_BITS_DEF = 16;
    localparam int CFG_W           = 9;
    localparam logic [CFG_W-1:0] CFG_LEN_RESET = 9'd16;

endpackage

[design/maf_ram.sv]
// Generic single-port-write, registered-read RAM.
module maf_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

[design/maf_div.sv]
// Iterative restoring divider: one quotient bit per cycle, sign applied at the end.
module maf_div #(
    parameter int N_W = 25,
    parameter int D_W = 9,
    parameter int Q_W = 16
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  logic [N_W-1:0] i_dividend,
    input  logic           i_neg,
    input  logic [D_W-1:0] i_divisor,
    output logic           o_done,
    output logic [Q_W-1:0] o_quotient
);

    localparam int CNT_W = $clog2(N_W + 1);

    logic [CNT_W-1:0] r_cnt;
    logic             r_done;
    logic [N_W-1:0]   r_quo;
    logic [D_W-1:0]   r_rem;
    logic [D_W-1:0]   r_div;
    logic             r_neg;

    logic [D_W:0]     w_trial;
    logic [D_W:0]     w_diff;
    logic             w_ge;
    logic [N_W-1:0]   w_signed_quo;

    assign w_trial = {r_rem, r_quo[N_W-1]};
    assign w_ge    = w_trial >= {1'b0, r_div};
    assign w_diff  = w_trial - {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= (r_cnt == CNT_W'(1));
            if (i_start) begin
                r_cnt <= CNT_W'(N_W);
            end else if (r_cnt != '0) begin
                r_cnt <= r_cnt - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_div <= i_divisor;
            r_neg <= i_neg;
        end else if (r_cnt != '0) begin
            r_quo <= {r_quo[N_W-2:0], w_ge};
            r_rem <= w_ge ? w_diff[D_W-1:0] : w_trial[D_W-1:0];
        end
    end

    assign w_signed_quo = r_neg ? (~r_quo + N_W'(1)) : r_quo;
    assign o_quotient   = w_signed_quo[Q_W-1:0];
    assign o_done       = r_done;

endmodule

[design/moving_average_filter_unit.sv]
// Moving average filter: sample store in RAM, running sum, iterative divide by fill count.
// After a request is accepted the sample is stored and the running sum updated; then the
//   bit-serial divider produces one quotient bit per cycle over the sum width.
// Input ready only while idle, so no new request is taken until the last result is registered.
// Reset (synchronous, active low) clears index, sum, fill and output valid and sets
//   the window length to 16; sample store contents are left undefined.
module moving_average_filter_unit
    import maf_pkg::*;
#(
    parameter int MAX_WINDOW  = MAX_WINDOW_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [CFG_W-1:0]              i_cfg_wdata,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic signed [SAMPLE_BITS-1:0] i_sample,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic signed [SAMPLE_BITS-1:0] o_average,
    output logic                          o_window_full
);

    localparam int ADDR_W = $clog2(MAX_WINDOW);
    localparam int LEN_W  = $clog2(MAX_WINDOW + 1);
    localparam int SUM_W  = SAMPLE_BITS + ADDR_W + 1;

    typedef enum logic [1:0] {S_IDLE, S_UPD, S_DIV, S_HOLD} t_state;

    t_state                   r_state, n_state;
    logic [CFG_W-1:0]         r_cfg;
    logic [ADDR_W-1:0]        r_slot;
    logic [ADDR_W-1:0]        r_slot_cur;
    logic signed [SUM_W-1:0]  r_sum, n_sum;
    logic [LEN_W-1:0]         r_fill, n_fill;
    logic signed [SAMPLE_BITS-1:0] r_x;
    logic                     r_was_full;
    logic                     r_win_full;
    logic                     r_out_valid;
    logic signed [SAMPLE_BITS-1:0] r_average;
    logic                     r_window_full;

    logic [LEN_W-1:0]         w_len;
    logic [ADDR_W-1:0]        w_slot_eff;
    logic [LEN_W-1:0]         w_slot_p1;
    logic [ADDR_W-1:0]        w_slot_next;
    logic                     w_accept;
    logic [SAMPLE_BITS-1:0]   w_rd_data;
    logic signed [SUM_W-1:0]  w_sub;
    logic [SUM_W-1:0]         w_abs_sum;
    logic                     w_div_start;
    logic                     w_div_done;
    logic [SAMPLE_BITS-1:0]   w_quot;
    logic                     w_out_free;

    always_comb begin
        if (r_cfg == '0) begin
            w_len = LEN_W'(1);
        end else if (int'(r_cfg) > MAX_WINDOW) begin
            w_len = LEN_W'(MAX_WINDOW);
        end else begin
            w_len = LEN_W'(r_cfg);
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign w_accept    = i_in_valid && o_in_ready;
    assign w_slot_eff  = (LEN_W'(r_slot) >= w_len) ? '0 : r_slot;
    assign w_slot_p1   = LEN_W'(r_slot_cur) + LEN_W'(1);
    assign w_slot_next = (w_slot_p1 >= w_len) ? '0 : w_slot_p1[ADDR_W-1:0];

    assign w_sub     = r_was_full ? SUM_W'(signed'(w_rd_data)) : '0;
    assign n_sum     = r_sum - w_sub + SUM_W'(r_x);
    assign n_fill    = (r_fill < w_len) ? (r_fill + LEN_W'(1)) : r_fill;
    assign w_abs_sum = n_sum[SUM_W-1] ? unsigned'(-n_sum) : unsigned'(n_sum);

    assign w_div_start = (r_state == S_UPD);
    assign w_out_free  = !r_out_valid || i_out_ready;

    maf_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (MAX_WINDOW)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (r_state == S_UPD),
        .i_wr_addr (r_slot_cur),
        .i_wr_data (r_x),
        .i_rd_en   (w_accept),
        .i_rd_addr (w_slot_eff),
        .o_rd_data (w_rd_data)
    );

    maf_div #(
        .N_W (SUM_W),
        .D_W (LEN_W),
        .Q_W (SAMPLE_BITS)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_abs_sum),
        .i_neg      (n_sum[SUM_W-1]),
        .i_divisor  (n_fill),
        .o_done     (w_div_done),
        .o_quotient (w_quot)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = S_UPD;
                end
            end
            S_UPD: begin
                n_state = S_DIV;
            end
            S_DIV: begin
                if (w_div_done) begin
                    n_state = w_out_free ? S_IDLE : S_HOLD;
                end
            end
            S_HOLD: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cfg       <= CFG_LEN_RESET;
            r_slot      <= '0;
            r_sum       <= '0;
            r_fill      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if ((((r_state == S_DIV) && w_div_done) || (r_state == S_HOLD)) && w_out_free) begin
                r_out_valid   <= 1'b1;
                r_average     <= signed'(w_quot);
                r_window_full <= r_win_full;
            end else if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (w_accept) begin
                r_slot_cur <= w_slot_eff;
                r_x        <= i_sample;
                r_was_full <= (r_fill >= w_len);
            end
            if (i_cfg_we) begin
                r_cfg  <= i_cfg_wdata;
                r_slot <= '0;
                r_sum  <= '0;
                r_fill <= '0;
            end else if (r_state == S_UPD) begin
                r_sum      <= n_sum;
                r_slot     <= w_slot_next;
                r_fill     <= n_fill;
                r_win_full <= (n_fill >= w_len);
            end
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_average     = r_average;
    assign o_window_full = r_window_full;

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> !o_in_ready)
        else $error("input ready high in the cycle after a request was taken");

    a_fill_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= w_len)
        else $error("fill count exceeds window length");

    a_slot_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        LEN_W'(r_slot) < w_len)
        else $error("write index outside window");

    a_done_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_done |-> (r_state == S_DIV))
        else $error("divider finished outside the divide state");

endmodule

[dv/tb_moving_average_filter_unit.sv]
// Self-checking testbench for the moving average filter unit.
module tb_moving_average_filter_unit;
    import maf_pkg::*;

    localparam int SAMPLE_W      = SAMPLE_BITS_DEF;
    localparam int WIN_MAX       = MAX_WINDOW_DEF;
    localparam int HIST_AW       = $clog2(WIN_MAX);
    localparam int BLOCK_LATENCY = 40;
    localparam int CYCLE_LIMIT   = 200000;
    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] average;
        logic                       window_full;
    } t_avg_result;

    logic                       i_clk = 1'b0;
    logic                       i_rst_n = 1'b0;
    logic                       i_cfg_we = 1'b0;
    logic [CFG_W-1:0]           i_cfg_wdata = '0;
    logic                       i_in_valid = 1'b0;
    logic                       o_in_ready;
    logic signed [SAMPLE_W-1:0] i_sample = '0;
    logic                       o_out_valid;
    logic                       i_out_ready = 1'b0;
    logic signed [SAMPLE_W-1:0] o_average;
    logic                       o_window_full;

    logic signed [SAMPLE_W-1:0] history [WIN_MAX];
    int unsigned                hist_slot;
    int unsigned                hist_fill;
    longint                     hist_sum;
    logic [CFG_W-1:0]           window_reg;

    t_avg_result pending_results[$];
    t_avg_result want;
    int          mismatches = 0;
    int          cycle_count = 0;
    int          hold_left = 0;
    bit          calm = 1'b0;

    moving_average_filter_unit dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_sample     (i_sample),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_average    (o_average),
        .o_window_full(o_window_full)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // hold off for a counted stretch when asked, else stall at random unless calm is set
    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            i_out_ready = 1'b0;
            hold_left--;
        end else begin
            i_out_ready = calm || ($urandom_range(99) >= 30);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_results.size() == 0) begin
                $error("result with no request outstanding: average %0d full %0b",
                       o_average, o_window_full);
                mismatches++;
            end else begin
                want = pending_results.pop_front();
                if (o_average !== want.average) begin
                    $error("average: expected %0d, got %0d", want.average, o_average);
                    mismatches++;
                end
                if (o_window_full !== want.window_full) begin
                    $error("window_full: expected %0b, got %0b",
                           want.window_full, o_window_full);
                    mismatches++;
                end
            end
        end
    end

    function automatic t_avg_result predict_average(input logic signed [SAMPLE_W-1:0] s);
        int unsigned span;
        longint      quotient;
        t_avg_result r;
        if (window_reg == 0)
            span = 1;
        else if (window_reg > WIN_MAX)
            span = WIN_MAX;
        else
            span = 32'(window_reg);
        if (hist_slot >= span)
            hist_slot = 0;
        if (hist_fill >= span)
            hist_sum -= longint'(history[hist_slot[HIST_AW-1:0]]);
        history[hist_slot[HIST_AW-1:0]] = s;
        hist_sum += longint'(s);
        hist_slot++;
        if (hist_slot >= span)
            hist_slot = 0;
        if (hist_fill < span)
            hist_fill++;
        quotient = hist_sum / longint'(hist_fill);
        r.average = quotient[SAMPLE_W-1:0];
        r.window_full = (hist_fill >= span);
        return r;
    endfunction

    function automatic logic signed [SAMPLE_W-1:0] pick_sample();
        int unsigned roll;
        roll = $urandom_range(15);
        if (roll < 2)
            return SAMPLE_MAX;
        else if (roll < 4)
            return SAMPLE_MIN;
        else if (roll == 4)
            return '0;
        return SAMPLE_W'($urandom);
    endfunction

    task automatic send_sample(input logic signed [SAMPLE_W-1:0] s);
        @(negedge i_clk);
        while (!calm && $urandom_range(99) < 30) begin
            i_in_valid = 1'b0;
            @(negedge i_clk);
        end
        i_in_valid = 1'b1;
        i_sample = s;
        do @(posedge i_clk); while (!o_in_ready);
        pending_results.push_back(predict_average(s));
    endtask

    task automatic drain_results();
        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (pending_results.size() != 0)
            @(posedge i_clk);
        repeat (BLOCK_LATENCY) @(posedge i_clk);
    endtask

    task automatic write_window_length(input logic [CFG_W-1:0] len);
        @(negedge i_clk);
        i_cfg_we = 1'b1;
        i_cfg_wdata = len;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        window_reg = len;
        hist_slot = 0;
        hist_sum = 0;
        hist_fill = 0;
    endtask

    task automatic run_phase(input logic [CFG_W-1:0] len, input int count);
        write_window_length(len);
        repeat (count) send_sample(pick_sample());
        drain_results();
    endtask

    task automatic test_reset_window();
        send_sample(SAMPLE_MAX);
        send_sample(SAMPLE_MAX);
        send_sample(SAMPLE_MIN);
        send_sample(SAMPLE_MIN);
        send_sample('0);
        send_sample(-16'sd1);
        send_sample(16'sd1);
        send_sample(16'sh5555);
        send_sample(16'shAAAA);
        send_sample(-16'sd3);
        drain_results();
    endtask

    task automatic test_length_extremes();
        // zero length behaves as one
        write_window_length('0);
        send_sample(SAMPLE_MIN);
        send_sample(16'sd7);
        send_sample(-16'sd7);
        drain_results();
        write_window_length(9'd1);
        send_sample(SAMPLE_MAX);
        send_sample(SAMPLE_MIN);
        drain_results();
        // oversized length saturates to the store depth
        write_window_length(9'd511);
        send_sample(SAMPLE_MAX);
        send_sample(SAMPLE_MAX);
        send_sample(-16'sd5);
        drain_results();
        write_window_length(9'd2);
        send_sample(-16'sd3);
        send_sample(-16'sd2);
        send_sample(16'sd9);
        send_sample(SAMPLE_MIN);
        drain_results();
    endtask

    task automatic test_random_windows();
        run_phase(9'd1, 25);
        run_phase(9'd2, 25);
        run_phase(9'd3, 25);
        run_phase(CFG_W'($urandom_range(4, 100)), 80);
        run_phase(9'd257, 20);
    endtask

    task automatic test_no_idle();
        calm = 1'b1;
        run_phase(CFG_W'($urandom_range(4, 40)), 60);
        calm = 1'b0;
    endtask

    task automatic test_output_backpressure();
        write_window_length(9'd5);
        @(posedge i_clk);
        hold_left = 400;
        repeat (15) send_sample(pick_sample());
        drain_results();
    endtask

    task automatic test_full_window();
        int                         i;
        logic signed [SAMPLE_W-1:0] s;
        write_window_length(9'd256);
        for (i = 0; i < 270; i++) begin
            case ((i / 64) % 4)
                0: begin
                    s = SAMPLE_MAX;
                end
                2: begin
                    s = SAMPLE_MIN;
                end
                default: begin
                    s = pick_sample();
                end
            endcase
            send_sample(s);
        end
        drain_results();
    endtask

    initial begin
        window_reg = CFG_LEN_RESET;
        hist_slot = 0;
        hist_sum = 0;
        hist_fill = 0;
        repeat (12) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_reset_window();
        test_length_extremes();
        test_random_windows();
        test_no_idle();
        test_output_backpressure();
        test_full_window();

        drain_results();
        if (mismatches == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
